// ===== design/hkst_pkg.sv =====
// hkst_pkg: sizes, operation and status codes, and slot addressing for the
// hashed key set table. No dependencies.
`default_nettype none

package hkst_pkg;

  localparam int NUM_BUCKETS  = 16;
  localparam int BUCKET_DEPTH = 8;
  localparam int TOTAL_SLOTS  = NUM_BUCKETS * BUCKET_DEPTH;

  localparam int KEY_W  = 32;
  localparam int OUT_W  = 4;
  // NUM_BUCKETS is a power of two: the bucket is the low bits of the key
  localparam int BIDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SLOT_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // flat slot address of slot s in bucket b
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [BIDX_W-1:0] b,
                                                   input logic [SLOT_W-1:0] s);
    return ADDR_W'(b) * ADDR_W'(BUCKET_DEPTH) + ADDR_W'(s);
  endfunction

endpackage

`default_nettype wire

// ===== design/hashed_key_set_table.sv =====
// hashed_key_set_table: set of 32-bit keys in fixed-slot buckets, bucket chosen
// by key modulo NUM_BUCKETS. Depends on hkst_pkg and hkst_key_ram.
//
//   channel  | ports                                         | handshake
//   ---------+-----------------------------------------------+-------------------------
//   input    | in_op, in_key                                 | start && !busy
//   result   | out_status, out_found, out_bucket_count,      | out_strobe, one cycle,
//            | out_bucket_index                              | no backpressure
//
// Steps: insert, delete and lookup are accepted in S_IDLE, read all BUCKET_DEPTH
// slots of the bucket through the key RAM's single read port (registered
// read) in S_SCAN, and update the set in S_FINISH; clear goes from accept
// straight to S_FINISH. The result strobe is registered.
// busy drops in the cycle the result is shown, so a new transaction can be
// accepted alongside the strobe. Reset (synchronous, rst_n low) empties the
// set at once: slot valid bits and bucket fills live in flops. Key RAM
// contents are never cleared; only valid slots are compared.
`default_nettype none

module hashed_key_set_table
  import hkst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [KEY_W-1:0]  in_key,
  output logic              out_strobe,
  output logic [1:0]        out_status,
  output logic              out_found,
  output logic [OUT_W-1:0]  out_bucket_count,
  output logic [OUT_W-1:0]  out_bucket_index
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  // transaction context
  op_t               op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [BIDX_W-1:0] bidx_r, bidx_nxt;

  // scan bookkeeping
  logic [FILL_W-1:0] issue_cnt_r, issue_cnt_nxt;   // reads issued so far
  logic              rd_pend_r, rd_pend_nxt;       // RAM data valid this cycle
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;       // slot of returning data
  logic              hit_r, hit_nxt;
  logic [SLOT_W-1:0] hit_slot_r, hit_slot_nxt;
  logic              free_found_r, free_found_nxt;
  logic [SLOT_W-1:0] free_slot_r, free_slot_nxt;   // lowest free slot

  // table state kept in flops
  logic [TOTAL_SLOTS-1:0] valid_r, valid_nxt;
  logic [FILL_W-1:0]      fill_r   [NUM_BUCKETS];
  logic [FILL_W-1:0]      fill_nxt [NUM_BUCKETS];

  // registered result
  logic              out_strobe_r, out_strobe_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_found_r, out_found_nxt;
  logic [OUT_W-1:0]  out_count_r, out_count_nxt;
  logic [OUT_W-1:0]  out_index_r, out_index_nxt;

  // key RAM port signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;

  logic              ret_valid;
  logic [FILL_W-1:0] cur_fill;

  hkst_key_ram u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = slot_addr(bidx_r, issue_cnt_r[SLOT_W-1:0]);
  // valid bit of the slot whose key is coming back from the RAM; nothing
  // changes valid bits during a scan, so no forwarding is needed
  assign ret_valid = valid_r[slot_addr(bidx_r, rd_slot_r)];
  assign cur_fill  = fill_r[bidx_r];

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    bidx_nxt       = bidx_r;
    issue_cnt_nxt  = issue_cnt_r;
    rd_pend_nxt    = rd_pend_r;
    rd_slot_nxt    = rd_slot_r;
    hit_nxt        = hit_r;
    hit_slot_nxt   = hit_slot_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    valid_nxt      = valid_r;
    fill_nxt       = fill_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    out_index_nxt  = out_index_r;
    ram_we         = 1'b0;
    ram_waddr      = slot_addr(bidx_r, free_slot_r);
    ram_re         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt         = op_t'(in_op);
          key_nxt        = in_key;
          bidx_nxt       = in_key[BIDX_W-1:0];
          issue_cnt_nxt  = '0;
          rd_pend_nxt    = 1'b0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = (op_t'(in_op) == OP_CLEAR) ? S_FINISH : S_SCAN;
        end
      end

      S_SCAN: begin
        // issue one slot read per cycle
        if (issue_cnt_r < FILL_W'(BUCKET_DEPTH)) begin
          ram_re        = 1'b1;
          issue_cnt_nxt = issue_cnt_r + 1'b1;
          rd_pend_nxt   = 1'b1;
          rd_slot_nxt   = issue_cnt_r[SLOT_W-1:0];
        end else begin
          rd_pend_nxt   = 1'b0;
        end
        // check the slot returned this cycle
        if (rd_pend_r) begin
          if (ret_valid && (ram_rdata == key_r)) begin
            hit_nxt      = 1'b1;
            hit_slot_nxt = rd_slot_r;
          end
          if (!ret_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = rd_slot_r;
          end
          if (rd_slot_r == SLOT_W'(BUCKET_DEPTH - 1)) begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        out_strobe_nxt = 1'b1;
        out_found_nxt  = hit_r;
        out_index_nxt  = OUT_W'(bidx_r);
        out_count_nxt  = OUT_W'(cur_fill);
        state_nxt      = S_IDLE;
        case (op_r)
          OP_CLEAR: begin
            valid_nxt      = '0;
            for (int b = 0; b < NUM_BUCKETS; b++) begin
              fill_nxt[b] = '0;
            end
            out_status_nxt = ST_DONE;
            out_found_nxt  = 1'b0;
            out_count_nxt  = '0;
            out_index_nxt  = '0;
          end
          OP_INSERT: begin
            if (hit_r) begin
              out_status_nxt = ST_PRESENT;
            end else if (!free_found_r) begin
              out_status_nxt = ST_FULL;
            end else begin
              ram_we                                  = 1'b1;
              valid_nxt[slot_addr(bidx_r, free_slot_r)] = 1'b1;
              fill_nxt[bidx_r]                        = cur_fill + 1'b1;
              out_count_nxt                           = OUT_W'(cur_fill + 1'b1);
              out_status_nxt                          = ST_DONE;
            end
          end
          OP_DELETE: begin
            if (hit_r) begin
              valid_nxt[slot_addr(bidx_r, hit_slot_r)] = 1'b0;
              if (cur_fill != '0) begin
                fill_nxt[bidx_r] = cur_fill - 1'b1;
                out_count_nxt    = OUT_W'(cur_fill - 1'b1);
              end
              out_status_nxt = ST_DONE;
            end else begin
              out_status_nxt = ST_NOT_FOUND;
            end
          end
          default: begin  // lookup
            out_status_nxt = hit_r ? ST_DONE : ST_NOT_FOUND;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    // payload and context, no reset needed
    op_r          <= op_nxt;
    key_r         <= key_nxt;
    bidx_r        <= bidx_nxt;
    rd_slot_r     <= rd_slot_nxt;
    hit_slot_r    <= hit_slot_nxt;
    free_slot_r   <= free_slot_nxt;
    out_status_r  <= out_status_nxt;
    out_found_r   <= out_found_nxt;
    out_count_r   <= out_count_nxt;
    out_index_r   <= out_index_nxt;
    if (!rst_n) begin
      state_r       <= S_IDLE;
      issue_cnt_r   <= '0;
      rd_pend_r     <= 1'b0;
      hit_r         <= 1'b0;
      free_found_r  <= 1'b0;
      valid_r       <= '0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        fill_r[b] <= '0;
      end
      out_strobe_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      issue_cnt_r   <= issue_cnt_nxt;
      rd_pend_r     <= rd_pend_nxt;
      hit_r         <= hit_nxt;
      free_found_r  <= free_found_nxt;
      valid_r       <= valid_nxt;
      fill_r        <= fill_nxt;
      out_strobe_r  <= out_strobe_nxt;
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_found        = out_found_r;
  assign out_bucket_count = out_count_r;
  assign out_bucket_index = out_index_r;

endmodule

`default_nettype wire

// ===== design/hkst_key_ram.sv =====
// hkst_key_ram: slot key store, one write and one read port, registered read.
// Depends on hkst_pkg.
`default_nettype none

module hkst_key_ram
  import hkst_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [KEY_W-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [KEY_W-1:0]  rdata
);

  logic [KEY_W-1:0] mem [TOTAL_SLOTS];
  logic [KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench: self-checking bench for hashed_key_set_table; drives insert, delete,
// lookup and clear transactions and checks every result strobe against its own set model.
// Depends on hkst_pkg and the hashed_key_set_table RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hkst_pkg::*;

  // one input transaction: operation plus key
  typedef struct {
    op_t              op;
    logic [KEY_W-1:0] key;
  } set_cmd_t;

  // one result transaction as the block should report it
  typedef struct {
    status_t          status;
    logic             found;
    logic [OUT_W-1:0] count;
    logic [OUT_W-1:0] index;
  } set_result_t;

  localparam int STALL_LIMIT  = 2000;             // cycles with no transaction at all
  localparam int DRAIN_CYCLES = BUCKET_DEPTH + 8; // settle time after the last result
  localparam int MAX_REPORTS  = 10;

  logic             clk   = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [1:0]       in_op = OP_INSERT;
  logic [KEY_W-1:0] in_key = '0;
  logic             busy;
  logic             out_strobe;
  logic [1:0]       out_status;
  logic             out_found;
  logic [OUT_W-1:0] out_bucket_count;
  logic [OUT_W-1:0] out_bucket_index;

  set_cmd_t    cmd_backlog[$];      // transactions not yet presented to the block
  set_result_t expected_results[$]; // predicted results, oldest first
  int          fail_count  = 0;
  int          stall_cycles = 0;
  int          idle_pct    = 0;     // chance in percent that the sender idles a cycle

  // shadow copy of the set: slot contents, slot valid bits and per-bucket fill
  logic [KEY_W-1:0] held_key   [NUM_BUCKETS][BUCKET_DEPTH];
  bit               held_valid [NUM_BUCKETS][BUCKET_DEPTH];
  int unsigned      held_count [NUM_BUCKETS];

  hashed_key_set_table u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_key           (in_key),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_bucket_count (out_bucket_count),
    .out_bucket_index (out_bucket_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one transaction to the shadow set and returns the result the block
  // owes for it. Bucket is the key modulo the bucket count; a new key goes to
  // the lowest free slot of its bucket.
  function automatic set_result_t apply_set_op(op_t op, logic [KEY_W-1:0] key);
    set_result_t r;
    int unsigned b;
    int          hit;
    int          free_at;
    r.status = ST_DONE;
    r.found  = 1'b0;
    r.count  = '0;
    r.index  = '0;
    if (op == OP_CLEAR) begin
      // clear wipes every bucket and reports all zeros
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        held_count[i] = 0;
        for (int s = 0; s < BUCKET_DEPTH; s++) held_valid[i][s] = 1'b0;
      end
      return r;
    end
    b       = key % NUM_BUCKETS;
    hit     = -1;
    free_at = -1;
    for (int s = 0; s < BUCKET_DEPTH; s++) begin
      // only valid slots are compared, so never-written keys are never read
      if (held_valid[b][s] && held_key[b][s] == key && hit < 0) hit = s;
      if (!held_valid[b][s] && free_at < 0) free_at = s;
    end
    r.found = (hit >= 0);
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          r.status = ST_PRESENT;
        end else if (free_at < 0) begin
          r.status = ST_FULL;
        end else begin
          held_key[b][free_at]   = key;
          held_valid[b][free_at] = 1'b1;
          held_count[b]++;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          held_valid[b][hit] = 1'b0;
          if (held_count[b] > 0) held_count[b]--;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: begin
        r.status = (hit >= 0) ? ST_DONE : ST_NOT_FOUND;
      end
    endcase
    r.count = OUT_W'(held_count[b]);
    r.index = OUT_W'(b);
    return r;
  endfunction

  function automatic void queue_cmd(op_t op, logic [KEY_W-1:0] key);
    set_cmd_t c;
    c.op  = op;
    c.key = key;
    cmd_backlog.push_back(c);
  endfunction

  // Random transactions aimed at two crowded buckets so that hits, duplicate
  // inserts, deletes of held keys and full buckets all come up often. A share
  // of fresh and fully random keys keeps misses and every key bit in play.
  task automatic queue_random_phase(int n);
    logic [KEY_W-1:0] pool[20];
    logic [3:0]       hot[2];
    logic [KEY_W-1:0] key;
    int               r;
    op_t              op;
    hot[0] = 4'($urandom_range(NUM_BUCKETS - 1));
    hot[1] = 4'($urandom_range(NUM_BUCKETS - 1));
    foreach (pool[i]) pool[i] = {28'($urandom() >> 4), hot[i % 2]};
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 70) key = pool[$urandom_range(19)];
      else if (r < 90) key = {28'($urandom() >> 4), hot[$urandom_range(1)]};
      else key = $urandom();
      r = $urandom_range(99);
      if (r < 42) op = OP_INSERT;
      else if (r < 64) op = OP_DELETE;
      else if (r < 97) op = OP_LOOKUP;
      else op = OP_CLEAR;
      queue_cmd(op, key);
    end
  endtask

  // Driver: a transaction is taken at an edge where start is high and busy
  // low. The prediction is made right there, so the shadow set follows the
  // order in which the block accepts work. start is written once per edge.
  always @(posedge clk) begin : drive
    set_cmd_t nxt;
    logic     taken;
    if (!rst_n) begin
      start  <= 1'b0;
      in_op  <= OP_INSERT;
      in_key <= '0;
    end else begin
      taken = start && !busy;
      if (taken) expected_results.push_back(apply_set_op(op_t'(in_op), in_key));
      if (start && !taken) begin
        // still waiting on busy: hold the transaction as it is
      end else if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = cmd_backlog.pop_front();
        start  <= 1'b1;
        in_op  <= nxt.op;
        in_key <= nxt.key;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: the strobe lasts one cycle and cannot be held off, so every
  // strobe seen at an edge is one result transaction.
  always @(posedge clk) begin : check
    set_result_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: status %0d found %0d count %0d index %0d",
                   out_status, out_found, out_bucket_count, out_bucket_index);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status || out_found !== want.found ||
            out_bucket_count !== want.count || out_bucket_index !== want.index) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"result differs: status %0d/%0d found %0d/%0d count %0d/%0d ",
                      "index %0d/%0d (expected/actual)"},
                     want.status, out_status, want.found, out_found,
                     want.count, out_bucket_count, want.index, out_bucket_index);
        end
      end
    end
  end

  // Watchdog: any accepted transaction on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("hashed_key_set_table: mismatch");
    $finish;
  end

  initial begin
    int idle_plan[4];
    idle_plan = '{0, 48, 0, 38};

    // directed: empty-set misses, duplicate insert, key extremes, filling
    // bucket 0 to the brim, insert into a full bucket, reuse of a freed slot,
    // clear, then life after clear
    queue_cmd(OP_LOOKUP, 32'h0000_0000);
    queue_cmd(OP_DELETE, 32'h0000_0000);
    queue_cmd(OP_INSERT, 32'h0000_0000);
    queue_cmd(OP_INSERT, 32'h0000_0000);
    queue_cmd(OP_INSERT, 32'hFFFF_FFFF);
    queue_cmd(OP_LOOKUP, 32'hFFFF_FFFF);
    for (int i = 1; i < BUCKET_DEPTH; i++) queue_cmd(OP_INSERT, KEY_W'(i * NUM_BUCKETS));
    queue_cmd(OP_INSERT, KEY_W'(BUCKET_DEPTH * NUM_BUCKETS));
    queue_cmd(OP_DELETE, KEY_W'(3 * NUM_BUCKETS));
    queue_cmd(OP_INSERT, KEY_W'(BUCKET_DEPTH * NUM_BUCKETS));
    queue_cmd(OP_LOOKUP, KEY_W'(BUCKET_DEPTH * NUM_BUCKETS));
    queue_cmd(OP_DELETE, 32'hFFFF_FFFF);
    queue_cmd(OP_LOOKUP, 32'hFFFF_FFFF);
    queue_cmd(OP_CLEAR,  32'hA5A5_5A5A);
    queue_cmd(OP_LOOKUP, 32'h0000_0000);
    queue_cmd(OP_INSERT, 32'h8000_0000);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // random part in phases of different sender idling
    foreach (idle_plan[p]) begin
      while (cmd_backlog.size() != 0) @(posedge clk);
      idle_pct = idle_plan[p];
      queue_random_phase(138);
    end

    // all stimulus taken, then every result in, then a little settle time
    while (cmd_backlog.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("hashed_key_set_table: match");
    end else begin
      $display("hashed_key_set_table: mismatch");
    end
    $finish;
  end

endmodule
